>>> rtl/glos_pkg.sv
// shared types and constants for the grid line-of-sight block
package glos_pkg;

    localparam int X_W = 7;
    localparam int Y_W = 5;
    localparam int RANGE_W = 7;
    localparam int ERR_W = RANGE_W + 3;

    localparam int GRID_WIDTH_DEF = 128;
    localparam int GRID_HEIGHT_DEF = 32;

    localparam logic [RANGE_W-1:0] VIEW_RANGE_RST = 7'd15;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic REG_VIEW_RANGE = 1'b0;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_WALK,
        ST_DONE
    } state_t;

endpackage

>>> rtl/glos_if.sv
// valid/ready channel interfaces for grid items and visibility results
interface glos_in_if;
    import glos_pkg::*;

    logic           valid;
    logic           ready;
    logic           opcode;
    logic [X_W-1:0] cell_x;
    logic [Y_W-1:0] cell_y;
    logic           cell_is_wall;
    logic [X_W-1:0] viewer_x;
    logic [Y_W-1:0] viewer_y;
    logic [X_W-1:0] target_x;
    logic [Y_W-1:0] target_y;

    modport source (
        output valid, opcode, cell_x, cell_y, cell_is_wall,
        output viewer_x, viewer_y, target_x, target_y,
        input  ready
    );

    modport sink (
        input  valid, opcode, cell_x, cell_y, cell_is_wall,
        input  viewer_x, viewer_y, target_x, target_y,
        output ready
    );
endinterface

interface glos_out_if;
    logic valid;
    logic ready;
    logic visible;

    modport source (
        output valid, visible,
        input  ready
    );

    modport sink (
        input  valid, visible,
        output ready
    );
endinterface

>>> rtl/glos_map.sv
// one-bit wall map memory, one write port and one registered read port
module glos_map #(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic              wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic              rdata
);

    logic mem [DEPTH];
    logic rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/grid_line_of_sight.sv
// grid line-of-sight top level: wall map, bresenham walk and apb register
// a write item is handled in idle; a query passes from idle through setup and walk
// to done (walk skipped when out of view range), at most one map read per walk step
// one item is in work at a time; the next is taken once the result is in the output register
// reset runs a clearing pass over all GRID_WIDTH*GRID_HEIGHT cells (4096 by default),
// during which no item is taken; view_range resets to 15
module grid_line_of_sight #(
    parameter int GRID_WIDTH  = glos_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = glos_pkg::GRID_HEIGHT_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    glos_in_if.sink                     in_ch,
    glos_out_if.source                  out_ch,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [glos_pkg::APB_AW-1:0] paddr,
    input  logic [glos_pkg::APB_DW-1:0] pwdata,
    output logic [glos_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);

    import glos_pkg::*;

    localparam int DEPTH = GRID_WIDTH * GRID_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CMP_W = 9;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    state_t state_reg, state_next;

    logic [RANGE_W-1:0] view_range_reg;
    logic [ADDR_W-1:0]  clr_reg, clr_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_vis_reg, out_vis_next;
    logic               chk_reg, chk_next;
    logic               blocked_reg, blocked_next;

    logic [X_W-1:0]     px_reg, px_next;
    logic [Y_W-1:0]     py_reg, py_next;
    logic [X_W-1:0]     tx_reg, tx_next;
    logic [Y_W-1:0]     ty_reg, ty_next;
    logic               sx_neg_reg, sx_neg_next;
    logic               sy_neg_reg, sy_neg_next;
    logic               xmaj_reg, xmaj_next;
    logic [RANGE_W-1:0] major_reg, major_next;
    logic [RANGE_W-1:0] step_reg, step_next;
    logic signed [ERR_W-1:0] err_reg, err_next;
    logic signed [ERR_W-1:0] keep_reg, keep_next;
    logic signed [ERR_W-1:0] move_reg, move_next;

    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic               mem_wdata;
    logic               mem_re;
    logic [ADDR_W-1:0]  mem_raddr;
    logic               mem_rdata;

    logic [X_W-1:0]     dx;
    logic [X_W-1:0]     dy;
    logic               out_range;
    logic               x_major;
    logic [RANGE_W-1:0] major_w;
    logic [RANGE_W-1:0] minor_w;
    logic signed [ERR_W-1:0] keep_w;
    logic signed [ERR_W-1:0] err0_w;
    logic               cell_in_grid;
    logic               walk_in_grid;
    logic [ADDR_W-1:0]  cell_addr;
    logic               cfg_wr;

    glos_map #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_map (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // apb register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            view_range_reg <= VIEW_RANGE_RST;
        end
        else if (cfg_wr && paddr[2] == REG_VIEW_RANGE)
        begin
            view_range_reg <= pwdata[RANGE_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_VIEW_RANGE)
        begin
            prdata = APB_DW'(view_range_reg);
        end
    end

    // query setup arithmetic
    always_comb
    begin
        if (tx_reg > px_reg)
        begin
            dx = tx_reg - px_reg;
        end
        else
        begin
            dx = px_reg - tx_reg;
        end
        if (ty_reg > py_reg)
        begin
            dy = X_W'(ty_reg - py_reg);
        end
        else
        begin
            dy = X_W'(py_reg - ty_reg);
        end
        out_range = (dx > view_range_reg) || (dy > view_range_reg);
        x_major = dx > dy;
        major_w = x_major ? dx : dy;
        minor_w = x_major ? dy : dx;
        keep_w = $signed({2'b00, minor_w, 1'b0});
        err0_w = keep_w - $signed({3'b000, major_w});
    end

    assign cell_in_grid = (CMP_W'(in_ch.cell_x) < CMP_W'(GRID_WIDTH))
                       && (CMP_W'(in_ch.cell_y) < CMP_W'(GRID_HEIGHT));
    assign walk_in_grid = (CMP_W'(px_reg) < CMP_W'(GRID_WIDTH))
                       && (CMP_W'(py_reg) < CMP_W'(GRID_HEIGHT));
    assign cell_addr = ADDR_W'(32'(in_ch.cell_y) * 32'(GRID_WIDTH) + 32'(in_ch.cell_x));
    assign mem_raddr = ADDR_W'(32'(py_reg) * 32'(GRID_WIDTH) + 32'(px_reg));

    // control sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg;
        out_vis_next   = out_vis_reg;
        chk_next       = 1'b0;
        blocked_next   = blocked_reg | (chk_reg & mem_rdata);
        px_next        = px_reg;
        py_next        = py_reg;
        tx_next        = tx_reg;
        ty_next        = ty_reg;
        sx_neg_next    = sx_neg_reg;
        sy_neg_next    = sy_neg_reg;
        xmaj_next      = xmaj_reg;
        major_next     = major_reg;
        step_next      = step_reg;
        err_next       = err_reg;
        keep_next      = keep_reg;
        move_next      = move_reg;
        mem_we         = 1'b0;
        mem_waddr      = cell_addr;
        mem_wdata      = in_ch.cell_is_wall;
        mem_re         = 1'b0;
        in_ch.ready    = 1'b0;

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = 1'b0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ch.ready = 1'b1;
                if (in_ch.valid)
                begin
                    if (in_ch.opcode == OP_WRITE)
                    begin
                        mem_we = cell_in_grid;
                    end
                    else
                    begin
                        px_next    = in_ch.viewer_x;
                        py_next    = in_ch.viewer_y;
                        tx_next    = in_ch.target_x;
                        ty_next    = in_ch.target_y;
                        state_next = ST_SETUP;
                    end
                end
            end
            ST_SETUP:
            begin
                sx_neg_next  = !(tx_reg > px_reg);
                sy_neg_next  = !(ty_reg > py_reg);
                xmaj_next    = x_major;
                major_next   = major_w;
                keep_next    = keep_w;
                err_next     = err0_w;
                move_next    = err0_w - $signed({3'b000, major_w});
                step_next    = '0;
                blocked_next = out_range;
                state_next   = out_range ? ST_DONE : ST_WALK;
            end
            ST_WALK:
            begin
                mem_re    = (step_reg != '0) && (step_reg != major_reg) && walk_in_grid;
                chk_next  = mem_re;
                step_next = step_reg + 1'b1;
                if (xmaj_reg)
                begin
                    px_next = sx_neg_reg ? px_reg - 1'b1 : px_reg + 1'b1;
                end
                else
                begin
                    py_next = sy_neg_reg ? py_reg - 1'b1 : py_reg + 1'b1;
                end
                if (err_reg < 0)
                begin
                    err_next = err_reg + keep_reg;
                end
                else
                begin
                    err_next = err_reg + move_reg;
                    if (xmaj_reg)
                    begin
                        py_next = sy_neg_reg ? py_reg - 1'b1 : py_reg + 1'b1;
                    end
                    else
                    begin
                        px_next = sx_neg_reg ? px_reg - 1'b1 : px_reg + 1'b1;
                    end
                end
                if (step_reg == major_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    out_vis_next   = !blocked_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            chk_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            chk_reg       <= chk_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_vis_reg <= out_vis_next;
        blocked_reg <= blocked_next;
        px_reg      <= px_next;
        py_reg      <= py_next;
        tx_reg      <= tx_next;
        ty_reg      <= ty_next;
        sx_neg_reg  <= sx_neg_next;
        sy_neg_reg  <= sy_neg_next;
        xmaj_reg    <= xmaj_next;
        major_reg   <= major_next;
        step_reg    <= step_next;
        err_reg     <= err_next;
        keep_reg    <= keep_next;
        move_reg    <= move_next;
    end

    assign out_ch.valid   = out_valid_reg;
    assign out_ch.visible = out_vis_reg;

    a_no_take_while_clearing: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !in_ch.ready
    ) else $error("item taken during clearing pass");

    a_result_from_done: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE)
    ) else $error("result loaded outside done state");

    a_step_bounded: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (step_reg <= major_reg)
    ) else $error("walk step beyond major distance");

    a_check_after_walk: assert property (
        @(posedge clk) disable iff (!rst_n)
        chk_reg |-> $past(state_reg == ST_WALK)
    ) else $error("map check without walk read");

endmodule

>>> tb/tb_grid_line_of_sight.sv
// self-checking testbench for grid_line_of_sight: directed table, then random items against a predictor
module tb_grid_line_of_sight;
    import glos_pkg::*;

    localparam int GRID_W = GRID_WIDTH_DEF;
    localparam int GRID_H = GRID_HEIGHT_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 140;
    localparam int SETTLE_CYCLES = 10;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_COUNT = 6;
    localparam int PHASE_ITEMS = 90;

    typedef struct {
        logic           opcode;
        logic [X_W-1:0] cell_x;
        logic [Y_W-1:0] cell_y;
        logic           cell_is_wall;
        logic [X_W-1:0] viewer_x;
        logic [Y_W-1:0] viewer_y;
        logic [X_W-1:0] target_x;
        logic [Y_W-1:0] target_y;
    } grid_item_t;

    typedef struct {
        grid_item_t item;
        bit         typed;
        logic       vis;
    } table_row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    glos_in_if  in_ch();
    glos_out_if out_ch();

    bit                 wall_grid [GRID_W*GRID_H];
    logic [RANGE_W-1:0] range_now = VIEW_RANGE_RST;
    logic               pending_vis [$];
    int                 fail_count = 0;
    int                 cycle_count = 0;
    bit                 idle_on = 1'b1;
    bit                 hold_req = 1'b0;

    grid_line_of_sight uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic flag_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        fail_count++;
    endtask

    // bresenham walk over the predicted wall grid, endpoints never tested
    function automatic logic sight_clear(int vx, int vy, int tx, int ty);
        int dx, dy, sx, sy, px, py, major, inc_keep, inc_move, err, i;
        bit x_major;
        dx = (tx > vx) ? tx - vx : vx - tx;
        sx = (tx > vx) ? 1 : -1;
        dy = (ty > vy) ? ty - vy : vy - ty;
        sy = (ty > vy) ? 1 : -1;
        if (dx > int'(range_now) || dy > int'(range_now))
            return 1'b0;
        x_major = dx > dy;
        major = x_major ? dx : dy;
        inc_keep = 2 * (x_major ? dy : dx);
        err = inc_keep - major;
        inc_move = err - major;
        px = vx;
        py = vy;
        for (i = 0; i <= major; i++)
        begin
            if (i != 0 && i != major && px >= 0 && py >= 0 && px < GRID_W && py < GRID_H
                && wall_grid[py*GRID_W + px])
                return 1'b0;
            if (x_major)
                px += sx;
            else
                py += sy;
            if (err < 0)
                err += inc_keep;
            else
            begin
                err += inc_move;
                if (x_major)
                    py += sy;
                else
                    px += sx;
            end
        end
        return 1'b1;
    endfunction

    function automatic grid_item_t noise_item();
        grid_item_t it;
        it.opcode       = 1'($urandom);
        it.cell_x       = X_W'($urandom);
        it.cell_y       = Y_W'($urandom);
        it.cell_is_wall = 1'($urandom);
        it.viewer_x     = X_W'($urandom);
        it.viewer_y     = Y_W'($urandom);
        it.target_x     = X_W'($urandom);
        it.target_y     = Y_W'($urandom);
        return it;
    endfunction

    function automatic table_row_t wr_row(int x, int y, bit wall);
        table_row_t row;
        row.item = noise_item();
        row.item.opcode = OP_WRITE;
        row.item.cell_x = X_W'(x);
        row.item.cell_y = Y_W'(y);
        row.item.cell_is_wall = wall;
        row.typed = 1'b0;
        row.vis = 1'b0;
        return row;
    endfunction

    function automatic table_row_t q_row(int vx, int vy, int tx, int ty, bit typed, logic vis);
        table_row_t row;
        row.item = noise_item();
        row.item.opcode = OP_QUERY;
        row.item.viewer_x = X_W'(vx);
        row.item.viewer_y = Y_W'(vy);
        row.item.target_x = X_W'(tx);
        row.item.target_y = Y_W'(ty);
        row.typed = typed;
        row.vis = vis;
        return row;
    endfunction

    // writes and queries mostly packed into a small window so walls get in the way
    function automatic grid_item_t gen_item(int fx, int fy);
        grid_item_t it;
        int span, roll;
        it = noise_item();
        roll = $urandom_range(0, 99);
        span = (range_now > 18) ? 20 : int'(range_now) + 2;
        if (roll < 40)
        begin
            it.opcode = OP_WRITE;
            if (roll >= 4)
            begin
                it.cell_x = X_W'(fx + int'($urandom_range(0, 15)));
                it.cell_y = Y_W'(fy + int'($urandom_range(0, 7)));
            end
            it.cell_is_wall = ($urandom_range(0, 9) < 6);
        end
        else
        begin
            it.opcode = OP_QUERY;
            if (roll < 88)
            begin
                it.viewer_x = X_W'(fx + int'($urandom_range(0, 15)));
                it.viewer_y = Y_W'(fy + int'($urandom_range(0, 7)));
                it.target_x = X_W'(int'(it.viewer_x) + int'($urandom_range(0, 2*span)) - span);
                it.target_y = Y_W'(int'(it.viewer_y) + int'($urandom_range(0, 2*span)) - span);
            end
        end
        return it;
    endfunction

    task automatic send_item(input grid_item_t it, input bit typed, input logic vis);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.opcode       <= it.opcode;
        in_ch.cell_x       <= it.cell_x;
        in_ch.cell_y       <= it.cell_y;
        in_ch.cell_is_wall <= it.cell_is_wall;
        in_ch.viewer_x     <= it.viewer_x;
        in_ch.viewer_y     <= it.viewer_y;
        in_ch.target_x     <= it.target_x;
        in_ch.target_y     <= it.target_y;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        if (it.opcode == OP_WRITE)
        begin
            if (int'(it.cell_x) < GRID_W && int'(it.cell_y) < GRID_H)
                wall_grid[int'(it.cell_y)*GRID_W + int'(it.cell_x)] = it.cell_is_wall;
        end
        else if (typed)
            pending_vis.push_back(vis);
        else
            pending_vis.push_back(sight_clear(int'(it.viewer_x), int'(it.viewer_y),
                                              int'(it.target_x), int'(it.target_y)));
        @(negedge clk);
    endtask

    // write view_range with junk in the upper bits, then read it back
    task automatic set_view_range(input logic [RANGE_W-1:0] v);
        logic [APB_DW-1:0] word;
        word = $urandom;
        word[RANGE_W-1:0] = v;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(4 * REG_VIEW_RANGE);
        pwdata  <= word;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata[RANGE_W-1:0] !== v)
            flag_mismatch($sformatf("view_range read %0d, expected %0d",
                                    prdata[RANGE_W-1:0], v));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        range_now = v;
    endtask

    always @(posedge clk)
    begin : result_check
        logic want;
        if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            if (pending_vis.size() == 0)
                flag_mismatch("result transfer with no query outstanding");
            else
            begin
                want = pending_vis.pop_front();
                if (out_ch.visible !== want)
                    flag_mismatch($sformatf("visible %0b, expected %0b", out_ch.visible, want));
            end
        end
    end

    // result side: random stalls plus one long hold-off
    initial
    begin : result_side
        int hold_count;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ch.ready <= 1'b0;
                for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++)
                    @(negedge clk);
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
        end
    end

    initial
    begin : stimulus
        table_row_t         dir_rows [$];
        logic [RANGE_W-1:0] phase_range [PHASE_COUNT];
        int                 fx, fy, p, n;

        in_ch.valid        = 1'b0;
        in_ch.opcode       = OP_WRITE;
        in_ch.cell_x       = '0;
        in_ch.cell_y       = '0;
        in_ch.cell_is_wall = 1'b0;
        in_ch.viewer_x     = '0;
        in_ch.viewer_y     = '0;
        in_ch.target_x     = '0;
        in_ch.target_y     = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;

        dir_rows = '{
            q_row(0, 0, 0, 0, 1, 1'b1),          // viewer on target
            q_row(0, 0, 127, 31, 1, 1'b0),       // far corner, out of range
            q_row(10, 10, 25, 10, 1, 1'b1),      // exactly at range
            q_row(10, 10, 26, 10, 1, 1'b0),      // one past range on x
            q_row(10, 0, 10, 16, 1, 1'b0),       // one past range on y
            wr_row(11, 10, 1'b1),
            q_row(10, 10, 25, 10, 1, 1'b0),      // wall in between
            q_row(11, 10, 13, 10, 1, 1'b1),      // wall on viewer cell
            q_row(9, 10, 11, 10, 1, 1'b1),       // wall on target cell
            wr_row(127, 31, 1'b1),
            wr_row(0, 0, 1'b1),
            q_row(127, 31, 112, 16, 0, 1'b0),    // equal distances from the corner
            q_row(0, 0, 3, 3, 0, 1'b0),
            wr_row(1, 1, 1'b1),
            q_row(0, 0, 3, 3, 0, 1'b0),          // diagonal through a wall
            wr_row(11, 10, 1'b0),
            q_row(10, 10, 25, 10, 1, 1'b1),      // wall cleared again
            q_row(126, 30, 127, 31, 0, 1'b0),
            wr_row(127, 0, 1'b1),
            q_row(112, 0, 127, 0, 0, 1'b0),
            q_row(20, 5, 10, 2, 0, 1'b0),        // negative x-major walk
            q_row(5, 20, 7, 5, 0, 1'b0)          // negative y-major walk
        };

        phase_range[0] = 7'd127;
        phase_range[1] = 7'd0;
        phase_range[2] = RANGE_W'($urandom_range(2, 126));
        phase_range[3] = 7'd1;
        phase_range[4] = RANGE_W'($urandom_range(2, 30));
        phase_range[5] = RANGE_W'($urandom_range(8, 40));

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[k])
            send_item(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].vis);

        for (p = 0; p < PHASE_COUNT; p++)
        begin
            in_ch.valid <= 1'b0;
            while (pending_vis.size() != 0)
                @(negedge clk);
            repeat (SETTLE_CYCLES) @(negedge clk);
            set_view_range(phase_range[p]);
            if (p == 2)
                hold_req = 1'b1;
            if (p == PHASE_COUNT - 1)
                idle_on = 1'b0;
            fx = $urandom_range(0, 127);
            fy = $urandom_range(0, 31);
            for (n = 0; n < PHASE_ITEMS; n++)
                send_item(gen_item(fx, fy), 1'b0, 1'b0);
        end

        in_ch.valid <= 1'b0;
        while (pending_vis.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> sim.f
rtl/glos_pkg.sv
rtl/glos_if.sv
rtl/glos_map.sv
rtl/grid_line_of_sight.sv
tb/tb_grid_line_of_sight.sv
